/* rtl/core/lzsd_pkg.sv */
package lzsd_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int ADDR_W      = $clog2(WINDOW_SIZE);
  localparam int COUNT_W     = 32;
  localparam int FLAG_W      = 16;
  localparam int BITS_W      = 5;
  localparam int CNT_W       = 5;
  localparam int MIN_MATCH   = 3;
  localparam int MAX_COPY    = 18;

  localparam logic KIND_CTRL = 1'b0;
  localparam logic KIND_LIT  = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_DIST   = 2'd1,
    ERR_KIND   = 2'd2,
    ERR_HALTED = 2'd3
  } err_t;

endpackage

/* rtl/core/lzsd_if.sv */
interface lzsd_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

interface lzsd_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic              byte_valid;
  logic              last;
  logic              need_literal;
  logic              done_res;
  lzsd_pkg::err_t    error_code;

  modport source (output valid, out_byte, byte_valid, last, need_literal, done_res,
                  error_code, input ready);
  modport sink (input valid, out_byte, byte_valid, last, need_literal, done_res,
                error_code, output ready);
endinterface

interface lzsd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lzsd_pkg::COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/core/lzss_split_stream_decoder.sv */
// split-stream lzss decoder, 4096-byte history
// items: request carries kind (0 control word, 1 literal byte) and a 16-bit value;
//   results.need_literal tells the sender which kind the next request must be
// results: one request per decoded byte or per status, last marks the final one
//   caused by an item; need_literal and done_res show the state after that item
// cfg: writes decoded_length; taken only while no match copy is running
// timing: a flag word, literal or error answer lands in the output register at
//   the edge that accepts the item
// a match copies its bytes one at a time (3 to 18 bytes, cut at
//   decoded_length): each byte is one registered read of the history memory
//   followed by its write-back at the next free output slot
// items is not ready during a copy or while a result waits in a full output
//   register; a stalled receiver simply holds the copy in its write-back step
// reset clears the byte count, flag state, error flag and decoded_length; history is
//   not cleared, a match can only reach bytes already written
module lzss_split_stream_decoder (
  input  logic               clk,
  input  logic               rst,
  lzsd_item_if.sink          items,
  lzsd_result_if.source      results,
  lzsd_cfg_if.sink           cfg
);

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WR} state_t;

  state_t                         state;
  logic [lzsd_pkg::COUNT_W-1:0]   dl;
  logic [lzsd_pkg::COUNT_W-1:0]   produced;
  logic [lzsd_pkg::FLAG_W-1:0]    flag_bits;
  logic [lzsd_pkg::BITS_W-1:0]    bits_left;
  logic                           error_seen;
  logic [lzsd_pkg::CNT_W-1:0]     cnt;
  logic [lzsd_pkg::ADDR_W-1:0]    src;
  logic                           fin_need;
  logic                           fin_done;

  logic                           out_valid;
  logic [7:0]                     out_byte;
  logic                           byte_valid;
  logic                           last;
  logic                           need_literal;
  logic                           done_res;
  lzsd_pkg::err_t                 error_code;

  logic [7:0]                     history [lzsd_pkg::WINDOW_SIZE];
  logic [7:0]                     mem_rdata;
  logic                           mem_we;
  logic [7:0]                     mem_wdata;

  logic                           out_free;
  logic                           accept;
  logic                           done_now;
  logic [lzsd_pkg::COUNT_W-1:0]   remaining;
  logic [lzsd_pkg::CNT_W-1:0]     copy_len;
  logic                           copy_fits;
  logic                           too_far;
  logic                           lit_slot;

  assign results.valid        = out_valid;
  assign results.out_byte     = out_byte;
  assign results.byte_valid   = byte_valid;
  assign results.last         = last;
  assign results.need_literal = need_literal;
  assign results.done_res     = done_res;
  assign results.error_code   = error_code;

  assign items.ready = (state == ST_IDLE) && out_free;
  assign cfg.ready   = (state == ST_IDLE);

  always_comb begin
    out_free  = !out_valid || results.ready;
    accept    = items.valid && items.ready;
    done_now  = produced >= dl;
    remaining = dl - produced;
    copy_len  = {1'b0, items.value[15:12]} + lzsd_pkg::CNT_W'(lzsd_pkg::MIN_MATCH);
    copy_fits = remaining <= {{(lzsd_pkg::COUNT_W-lzsd_pkg::CNT_W){1'b0}}, copy_len};
    too_far   = {{(lzsd_pkg::COUNT_W-lzsd_pkg::ADDR_W){1'b0}},
                 items.value[lzsd_pkg::ADDR_W-1:0]} >= produced;
    lit_slot  = !error_seen && !done_now && (bits_left != '0) && flag_bits[lzsd_pkg::FLAG_W-1];
    mem_we    = (accept && lit_slot && (items.kind == lzsd_pkg::KIND_LIT)) ||
                ((state == ST_WR) && out_free);
    mem_wdata = (state == ST_WR) ? mem_rdata : items.value[7:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[produced[lzsd_pkg::ADDR_W-1:0]] <= mem_wdata;
    end
    mem_rdata <= history[src];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dl         <= '0;
      produced   <= '0;
      flag_bits  <= '0;
      bits_left  <= '0;
      error_seen <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        dl <= cfg.data;
      end
      if (out_free) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            out_valid    <= 1'b1;
            out_byte     <= '0;
            byte_valid   <= 1'b0;
            last         <= 1'b1;
            need_literal <= 1'b0;
            done_res     <= 1'b0;
            error_code   <= lzsd_pkg::ERR_OK;
            if (error_seen || done_now) begin
              done_res   <= done_now;
              error_code <= lzsd_pkg::ERR_HALTED;
            end else if (bits_left == '0) begin
              if (items.kind != lzsd_pkg::KIND_CTRL) begin
                error_seen <= 1'b1;
                error_code <= lzsd_pkg::ERR_KIND;
              end else begin
                flag_bits    <= items.value;
                bits_left    <= lzsd_pkg::BITS_W'(lzsd_pkg::FLAG_W);
                need_literal <= items.value[lzsd_pkg::FLAG_W-1];
              end
            end else if (flag_bits[lzsd_pkg::FLAG_W-1]) begin
              if (items.kind != lzsd_pkg::KIND_LIT) begin
                error_seen <= 1'b1;
                error_code <= lzsd_pkg::ERR_KIND;
              end else begin
                produced     <= produced + 1'b1;
                flag_bits    <= {flag_bits[lzsd_pkg::FLAG_W-2:0], 1'b0};
                bits_left    <= bits_left - 1'b1;
                out_byte     <= items.value[7:0];
                byte_valid   <= 1'b1;
                done_res     <= (remaining == 1);
                need_literal <= (remaining != 1) && (bits_left != 1) &&
                                flag_bits[lzsd_pkg::FLAG_W-2];
              end
            end else if (items.kind != lzsd_pkg::KIND_CTRL) begin
              error_seen <= 1'b1;
              error_code <= lzsd_pkg::ERR_KIND;
            end else if (too_far) begin
              error_seen <= 1'b1;
              error_code <= lzsd_pkg::ERR_DIST;
            end else begin
              // match: status fixed now, bytes follow from the copy loop
              out_valid <= 1'b0;
              flag_bits <= {flag_bits[lzsd_pkg::FLAG_W-2:0], 1'b0};
              bits_left <= bits_left - 1'b1;
              cnt       <= copy_fits ? remaining[lzsd_pkg::CNT_W-1:0] : copy_len;
              src       <= produced[lzsd_pkg::ADDR_W-1:0] -
                           items.value[lzsd_pkg::ADDR_W-1:0] - 1'b1;
              fin_done  <= copy_fits;
              fin_need  <= !copy_fits && (bits_left != 1) && flag_bits[lzsd_pkg::FLAG_W-2];
              state     <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_byte     <= mem_rdata;
            byte_valid   <= 1'b1;
            last         <= (cnt == 1);
            need_literal <= fin_need;
            done_res     <= fin_done;
            error_code   <= lzsd_pkg::ERR_OK;
            produced     <= produced + 1'b1;
            src          <= src + 1'b1;
            cnt          <= cnt - 1'b1;
            state        <= (cnt == 1) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_copy_advances: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) && out_free |=> produced == $past(produced) + 1'b1)
    else $error("copy byte did not advance the output count");

  a_copy_count_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (cnt != '0) && (cnt <= lzsd_pkg::CNT_W'(lzsd_pkg::MAX_COPY)))
    else $error("copy count out of range");

  a_copy_within_length: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (produced < dl))
    else $error("copy ran past decoded length");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen |=> error_seen)
    else $error("error flag cleared without reset");

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    bits_left <= lzsd_pkg::BITS_W'(lzsd_pkg::FLAG_W))
    else $error("flag bit count out of range");

endmodule
